[hw/rtl/assert_macros.svh]
// Assertion macros used by the scan sequencer of the cache directory.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside of reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
// Expression must never be true outside of reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

[hw/rtl/ecd_pkg.sv]
// Shared types and constants of the expiring cache directory.
`timescale 1ns / 1ps
`default_nettype none

package ecd_pkg;

   localparam int KEY_W  = 32;
   localparam int TIME_W = 32;
   localparam int SLOT_W = 4;

   // Operation codes carried by req_func.
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   // One directory slot as it is kept in the slot memory.
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic              has_expiry;
      logic [TIME_W-1:0] expiry;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   // Write request from the sequencer to the slot memory.
   typedef struct packed {
      logic      en;
      entry_type data;
   } mem_wr_type;

endpackage

`default_nettype wire

[hw/rtl/ecd_mem.sv]
// Slot memory with one registered read port, one write port and per-slot valid bits.
`timescale 1ns / 1ps
`default_nettype none

module ecd_mem #(
   parameter int ENTRIES = 16,
   localparam int IdxW = $clog2(ENTRIES)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [IdxW-1:0]      rd_addr,
   output ecd_pkg::entry_type        rd_entry,
   input  wire ecd_pkg::mem_wr_type  wr,
   input  wire logic [IdxW-1:0]      wr_addr
);

   ecd_pkg::entry_type mem_ff [ENTRIES];
   ecd_pkg::entry_type rd_data_ff;
   logic               rd_valid_ff;
   logic [ENTRIES-1:0] valid_ff;

   // Storage array: written and read in a clocked block, no reset.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Valid bits: a slot never written reads as all zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

[hw/rtl/ecd_ctrl.sv]
// Scan sequencer: walks the slot memory for lookups and victim selection.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ecd_ctrl #(
   parameter int ENTRIES = 16,
   localparam int IdxW = $clog2(ENTRIES)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Request channel
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_func,
   input  wire logic [ecd_pkg::KEY_W-1:0]    req_key,
   input  wire logic [ecd_pkg::TIME_W-1:0]   req_now,
   input  wire logic                         req_has_expiry,
   input  wire logic [ecd_pkg::TIME_W-1:0]   req_expiry_time,
   // Response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_hit,
   output logic                              rsp_stale,
   output logic [ecd_pkg::SLOT_W-1:0]        rsp_slot,
   // Slot memory
   output logic                              rd_en,
   output logic [IdxW-1:0]                   rd_addr,
   input  wire ecd_pkg::entry_type           rd_entry,
   output ecd_pkg::mem_wr_type               wr,
   output logic [IdxW-1:0]                   wr_addr
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [IdxW-1:0]                cnt_ff, cnt_in;
   logic                           func_ff, func_in;
   logic [ecd_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [ecd_pkg::TIME_W-1:0]     now_ff, now_in;
   logic                           hx_ff, hx_in;
   logic [ecd_pkg::TIME_W-1:0]     exp_ff, exp_in;
   logic [IdxW-1:0]                best_ff, best_in;
   logic [ecd_pkg::TIME_W-1:0]     best_stamp_ff, best_stamp_in;
   logic                           res_hit_ff, res_hit_in;
   logic                           res_stale_ff, res_stale_in;
   logic [IdxW-1:0]                res_slot_ff, res_slot_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic                           rsp_stale_ff, rsp_stale_in;
   logic [ecd_pkg::SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;

   logic                           req_fire;
   logic                           last;
   logic                           match;
   logic                           expired;
   logic                           better;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign last      = (cnt_ff == IdxW'(ENTRIES - 1));
   assign match     = (rd_entry.key == key_ff);
   assign expired   = (now_ff > rd_entry.expiry);
   assign better    = (cnt_ff == '0) || (rd_entry.stamp < best_stamp_ff);

   // Next-state logic: one slot is examined per cycle while the next one is read.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      hx_in         = hx_ff;
      exp_in        = exp_ff;
      best_in       = best_ff;
      best_stamp_in = best_stamp_ff;
      res_hit_in    = res_hit_ff;
      res_stale_in  = res_stale_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_stale_in  = rsp_stale_ff;
      rsp_slot_in   = rsp_slot_ff;
      rd_en         = 1'b0;
      rd_addr       = cnt_ff + IdxW'(1);
      wr.en         = 1'b0;
      wr.data       = rd_entry;
      wr.data.stamp = '0;
      wr_addr       = cnt_ff;

      // The output register empties when the transaction is taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in      = req_func;
               key_in       = req_key;
               now_in       = req_now;
               hx_in        = req_has_expiry;
               exp_in       = req_expiry_time;
               cnt_in       = '0;
               res_hit_in   = 1'b0;
               res_stale_in = 1'b0;
               res_slot_in  = '0;
               // A lookup of the empty key misses without touching the slots.
               if (req_func == ecd_pkg::FUNC_LOOKUP && req_key == '0) begin
                  state_in = ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            rd_en  = !last;
            cnt_in = cnt_ff + IdxW'(1);
            if (func_ff == ecd_pkg::FUNC_INSERT) begin
               // Track the lowest-indexed slot with the smallest stamp.
               if (better) begin
                  best_in       = cnt_ff;
                  best_stamp_in = rd_entry.stamp;
               end
               if (last) begin
                  wr.en              = 1'b1;
                  wr_addr            = best_in;
                  wr.data.key        = key_ff;
                  wr.data.has_expiry = hx_ff;
                  wr.data.expiry     = exp_ff;
                  wr.data.stamp      = now_ff;
                  res_slot_in        = best_in;
                  state_in           = ST_DONE;
               end
            end else begin
               if (last) begin
                  state_in = ST_DONE;
               end
               if (match) begin
                  if (!rd_entry.has_expiry) begin
                     res_hit_in  = 1'b1;
                     res_slot_in = cnt_ff;
                     state_in    = ST_DONE;
                  end else if (expired) begin
                     // Stale match: clear its stamp so it is evicted before any entry with a nonzero stamp.
                     wr.en        = 1'b1;
                     res_hit_in   = 1'b0;
                     res_stale_in = 1'b1;
                     res_slot_in  = cnt_ff;
                     state_in     = ST_DONE;
                  end else begin
                     res_hit_in  = 1'b1;
                     res_slot_in = cnt_ff;
                  end
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_stale_in = res_stale_ff;
               rsp_slot_in  = ecd_pkg::SLOT_W'(res_slot_ff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      func_ff       <= func_in;
      key_ff        <= key_in;
      now_ff        <= now_in;
      hx_ff         <= hx_in;
      exp_ff        <= exp_in;
      best_ff       <= best_in;
      best_stamp_ff <= best_stamp_in;
      res_hit_ff    <= res_hit_in;
      res_stale_ff  <= res_stale_in;
      res_slot_ff   <= res_slot_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_stale_ff  <= rsp_stale_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_stale = rsp_stale_ff;
   assign rsp_slot  = rsp_slot_ff;

   // A lookup result is never both a hit and stale.
   `ASSERT_NEVER(a_hit_and_stale, clock, reset, rsp_valid_ff && rsp_hit_ff && rsp_stale_ff)
   // An insert never reports a hit or a stale entry.
   `ASSERT_NEVER(a_insert_flags, clock, reset,
      state_ff == ST_DONE && func_ff == ecd_pkg::FUNC_INSERT && (res_hit_ff || res_stale_ff))
   // A lookup of the empty key never scans the slots.
   `ASSERT_NEVER(a_zero_key_scan, clock, reset,
      state_ff == ST_SCAN && func_ff == ecd_pkg::FUNC_LOOKUP && key_ff == '0)
   // An accepted transaction always leaves the idle state.
   `ASSERT_PROP(a_accept_busy, clock, reset, req_fire |=> state_ff != ST_IDLE)

endmodule

`default_nettype wire

[hw/rtl/expiring_cache_directory.sv]
// Top level of the expiring cache directory.
//
// Usage: a request transaction on the req_ channel carries an operation (req_func:
// lookup or insert), a hashed key, the current time and, for inserts, the expiry
// data. Each request produces exactly one response transaction on the rsp_ channel
// with hit, stale and slot. Both channels use valid/ready handshakes.
// Scan: an insert scans every slot, one per cycle out of the slot memory, before
// it responds. A lookup stops at a hit without expiry or at a stale match; a
// lookup of key zero skips the scan. The block takes no new request until the
// response of the last one has moved into the output register.
// Reset: all slots read as empty at once through per-slot valid bits; no clearing
// pass is needed and the block accepts a request in the first cycle after reset.
// Stalls: a finished response waits in an output register; the block accepts the
// next request meanwhile, but holds its own result until that register is taken.
`timescale 1ns / 1ps
`default_nettype none

module expiring_cache_directory #(
   parameter int ENTRIES = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_func,
   input  wire logic [ecd_pkg::KEY_W-1:0]    req_key,
   input  wire logic [ecd_pkg::TIME_W-1:0]   req_now,
   input  wire logic                         req_has_expiry,
   input  wire logic [ecd_pkg::TIME_W-1:0]   req_expiry_time,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_hit,
   output logic                              rsp_stale,
   output logic [ecd_pkg::SLOT_W-1:0]        rsp_slot
);

   localparam int IdxW = $clog2(ENTRIES);

   logic                 rd_en;
   logic [IdxW-1:0]      rd_addr;
   ecd_pkg::entry_type   rd_entry;
   ecd_pkg::mem_wr_type  wr;
   logic [IdxW-1:0]      wr_addr;

   // Scan sequencer.
   ecd_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_now         (req_now),
      .req_has_expiry  (req_has_expiry),
      .req_expiry_time (req_expiry_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_stale       (rsp_stale),
      .rsp_slot        (rsp_slot),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_entry        (rd_entry),
      .wr              (wr),
      .wr_addr         (wr_addr)
   );

   // Slot memory.
   ecd_mem #(
      .ENTRIES (ENTRIES)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr       (wr),
      .wr_addr  (wr_addr)
   );

endmodule

`default_nettype wire
